// ----- src/sync_frame_receiver_crc16_defines.svh -----
// ----------------------------------------------------------------------------
// sync_frame_receiver_crc16 assertion macros
// Concurrent assertion helpers shared by the frame receiver RTL.
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAME_RECEIVER_CRC16_DEFINES_SVH
`define SYNC_FRAME_RECEIVER_CRC16_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define SFR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sfr: implication check failed");
// next-cycle implication
`define SFR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sfr: next-cycle check failed");
`else
`define SFR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SFR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- src/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants and types of the sync frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned PacketBytesDefault = 16;

  localparam logic [7:0]  SyncFirst  = 8'h53;  // 'S'
  localparam logic [7:0]  SyncSecond = 8'h50;  // 'P'
  localparam logic [15:0] CrcSeed    = 16'hFFFF;
  localparam logic [15:0] CrcPoly    = 16'hA001;

  typedef struct packed {
    logic       feed;
    logic       from_seed;
    logic [7:0] data;
  } crc_cmd_t;

  typedef struct packed {
    logic        busy;
    logic [15:0] crc;
  } crc_sts_t;

endpackage

// ----- src/sfr_crc_unit.sv -----
// ----------------------------------------------------------------------------
// sfr_crc_unit
// Bit-serial CRC-16/MODBUS engine: one polynomial step per cycle.
// ----------------------------------------------------------------------------
module sfr_crc_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfr_pkg::crc_cmd_t cmd_i,
  output sfr_pkg::crc_sts_t sts_o
);
  import sfr_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [15:0] step;

  assign step = crc_q[0] ? ((crc_q >> 1) ^ CrcPoly) : (crc_q >> 1);

  always_comb begin
    crc_d  = crc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (cmd_i.feed) begin
      crc_d  = (cmd_i.from_seed ? CrcSeed : crc_q) ^ {8'h00, cmd_i.data};
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      crc_d = step;
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CrcSeed;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.crc  = crc_q;

endmodule

// ----- src/sfr_frame_store.sv -----
// ----------------------------------------------------------------------------
// sfr_frame_store
// Frame byte memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module sfr_frame_store #(
  parameter int unsigned Depth = sfr_pkg::PacketBytesDefault,
  parameter int unsigned Aw    = $clog2(Depth)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [Aw-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [Aw-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);
  import sfr_pkg::*;

  logic [7:0] mem_q [Depth];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- src/sync_frame_receiver_crc16.sv -----
// ----------------------------------------------------------------------------
// sync_frame_receiver_crc16
// Hunts for the 'S','P' header, collects a frame, checks its CRC-16/MODBUS
// and replays a good frame byte by byte.
// ----------------------------------------------------------------------------
// channel | dir | handshake              | word
// in      | in  | in_valid_i / in_stall_o | in_byte_i
// out     | out | out_valid_o / out_stall_i | frame_byte_o, byte_position_o,
//         |     |                        | last_byte_o
//
// A word that feeds the CRC holds the input while it is accepted, loaded and
// run through eight serial CRC steps in sfr_crc_unit; CRC bytes and dropped
// words do not. A good frame is replayed word by word (registered memory read,
// then output load, held while out_stall_i is held); input stalls meanwhile.
// Reset is asynchronous; the frame memory needs no clearing pass.
// ----------------------------------------------------------------------------
`include "sync_frame_receiver_crc16_defines.svh"

module sync_frame_receiver_crc16 #(
  parameter int unsigned PACKET_BYTES = sfr_pkg::PacketBytesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] frame_byte_o,
  output logic [5:0] byte_position_o,
  output logic       last_byte_o
);
  import sfr_pkg::*;

  localparam int unsigned Aw = $clog2(PACKET_BYTES);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CRC  = 4'b0010,
    ST_RD   = 4'b0100,
    ST_LOAD = 4'b1000
  } state_e;

  typedef enum logic [2:0] {
    PH_HUNT_S = 3'b001,
    PH_HUNT_P = 3'b010,
    PH_BODY   = 3'b100
  } phase_e;

  state_e      state_q, state_d;
  phase_e      phase_q, phase_d;
  logic [6:0]  fill_q, fill_d;
  logic [7:0]  rx_lo_q, rx_lo_d;
  logic [5:0]  rd_ptr_q, rd_ptr_d;
  logic        out_valid_q;
  logic [7:0]  byte_q;
  logic [5:0]  pos_q;
  logic        last_q;

  logic          wr_en;
  logic [Aw-1:0] wr_addr;
  logic          rd_en;
  logic [7:0]    rd_data;
  crc_cmd_t      crc_cmd;
  crc_sts_t      crc_sts;

  logic slot_free, out_load, rd_last, is_last, crc_ok, do_start, do_idle;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign rd_last   = (rd_ptr_q == 6'(PACKET_BYTES - 1));
  assign is_last   = (fill_q == 7'(PACKET_BYTES - 1));
  assign crc_ok    = (crc_sts.crc == {in_byte_i, rx_lo_q});

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    fill_d    = fill_q;
    rx_lo_d   = rx_lo_q;
    rd_ptr_d  = rd_ptr_q;
    wr_en     = 1'b0;
    wr_addr   = fill_q[Aw-1:0];
    rd_en     = 1'b0;
    out_load  = 1'b0;
    do_start  = 1'b0;
    do_idle   = 1'b0;
    crc_cmd.feed      = 1'b0;
    crc_cmd.from_seed = 1'b0;
    crc_cmd.data      = in_byte_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (phase_q)
            PH_HUNT_S: begin
              do_start = (in_byte_i == SyncFirst);
            end
            PH_HUNT_P: begin
              if (in_byte_i == SyncSecond) begin
                wr_en        = 1'b1;
                fill_d       = 7'd2;
                phase_d      = PH_BODY;
                crc_cmd.feed = 1'b1;
                state_d      = ST_CRC;
              end else if (in_byte_i == SyncFirst) begin
                do_start = 1'b1;
              end else begin
                do_idle = 1'b1;
              end
            end
            PH_BODY: begin
              if (fill_q >= 7'(PACKET_BYTES)) begin
                do_idle = 1'b1;
              end else begin
                wr_en  = 1'b1;
                fill_d = fill_q + 7'd1;
                if (fill_q < 7'(PACKET_BYTES - 2)) begin
                  crc_cmd.feed = 1'b1;
                  state_d      = ST_CRC;
                end else if (!is_last) begin
                  rx_lo_d = in_byte_i;
                end else if (crc_ok) begin
                  rd_ptr_d = '0;
                  state_d  = ST_RD;
                end else if (in_byte_i == SyncFirst) begin
                  do_start = 1'b1;
                end else begin
                  do_idle = 1'b1;
                end
              end
            end
            default: do_idle = 1'b1;
          endcase
        end
      end
      ST_CRC: begin
        if (!crc_sts.busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_RD: begin
        rd_en   = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (rd_last) begin
            state_d = ST_IDLE;
            phase_d = PH_HUNT_S;
            fill_d  = '0;
          end else begin
            rd_ptr_d = rd_ptr_q + 6'd1;
            state_d  = ST_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // start of a new frame with this 'S' as word 0
    if (do_start) begin
      wr_en             = 1'b1;
      wr_addr           = '0;
      fill_d            = 7'd1;
      phase_d           = PH_HUNT_P;
      crc_cmd.feed      = 1'b1;
      crc_cmd.from_seed = 1'b1;
      state_d           = ST_CRC;
    end
    if (do_idle) begin
      phase_d = PH_HUNT_S;
      fill_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_HUNT_S;
      fill_q      <= '0;
      rd_ptr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      fill_q   <= fill_d;
      rd_ptr_q <= rd_ptr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rx_lo_q <= rx_lo_d;
    if (out_load) begin
      byte_q <= rd_data;
      pos_q  <= rd_ptr_q;
      last_q <= rd_last;
    end
  end

  sfr_crc_unit u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (crc_cmd),
    .sts_o  (crc_sts)
  );

  sfr_frame_store #(
    .Depth (PACKET_BYTES),
    .Aw    (Aw)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (in_byte_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_ptr_q[Aw-1:0]),
    .rd_data_o (rd_data)
  );

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign frame_byte_o    = byte_q;
  assign byte_position_o = pos_q;
  assign last_byte_o     = last_q;

  `SFR_ASSERT_IMP(a_crc_idle, clk_i, rst_ni, state_q == ST_IDLE, !crc_sts.busy)
  `SFR_ASSERT_IMP(a_fill_max, clk_i, rst_ni, 1'b1, fill_q <= 7'(PACKET_BYTES))
  `SFR_ASSERT_IMP(a_last_pos, clk_i, rst_ni, out_valid_o && last_byte_o,
                  byte_position_o == 6'(PACKET_BYTES - 1))
  `SFR_ASSERT_NXT(a_emit_end, clk_i, rst_ni, state_q == ST_LOAD && slot_free && rd_last,
                  state_q == ST_IDLE && fill_q == 7'd0)
  `SFR_ASSERT_IMP(a_emit_full, clk_i, rst_ni, state_q == ST_RD || state_q == ST_LOAD,
                  fill_q == 7'(PACKET_BYTES))

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds sync_frame_receiver_crc16 with a byte stream of good frames, corrupted
// frames, broken headers, truncated frames and noise, tracks the hunt state and
// CRC-16/MODBUS of the stream on the side, and checks every replayed frame word
// against the frame bytes this tracker says must come out.
// ----------------------------------------------------------------------------
module testbench;
  import sfr_pkg::*;

  localparam int FrameLen  = PacketBytesDefault;
  localparam int HoldOff   = 300;
  localparam int IdleLimit = 3000;
  localparam int TailWait  = 40;

  typedef enum logic [1:0] {
    WaitFirst   = 2'd0,
    WaitSecond  = 2'd1,
    CollectBody = 2'd2,
    PhaseSpare  = 2'd3
  } hunt_e;

  typedef struct {
    logic [7:0] data;
    logic [5:0] pos;
    logic       last;
  } frame_word_t;

  typedef logic [7:0] frame_t [FrameLen];

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] frame_byte_o;
  logic [5:0] byte_position_o;
  logic       last_byte_o;

  logic [7:0]  link_bytes_q[$];
  frame_word_t frame_words_q[$];

  // side copy of the receiver state
  hunt_e       rx_phase = WaitFirst;
  logic [6:0]  rx_fill  = '0;
  logic [7:0]  rx_store [FrameLen];
  logic [15:0] rx_crc   = CrcSeed;

  int unsigned errors      = 0;
  int unsigned idle_cycles = 0;
  int unsigned words_seen  = 0;
  int          tx_gap      = 0;
  int          rx_gap      = 0;
  int          hold_left   = 0;
  int          calm_timer  = 0;
  logic        calm        = 1'b0;

  sync_frame_receiver_crc16 u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .frame_byte_o   (frame_byte_o),
    .byte_position_o(byte_position_o),
    .last_byte_o    (last_byte_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [15:0] modbus_crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void restart_frame();
    rx_store[0] = SyncFirst;
    rx_fill     = 7'd1;
    rx_phase    = WaitSecond;
    rx_crc      = modbus_crc_step(CrcSeed, SyncFirst);
  endfunction

  function automatic void drop_frame();
    rx_phase = WaitFirst;
    rx_fill  = '0;
    rx_crc   = CrcSeed;
  endfunction

  function automatic void track_link_byte(logic [7:0] b);
    frame_word_t w;
    case (rx_phase)
      WaitFirst: begin
        if (b == SyncFirst) restart_frame();
      end
      WaitSecond: begin
        if (b == SyncSecond) begin
          rx_store[1] = b;
          rx_fill     = 7'd2;
          rx_phase    = CollectBody;
          rx_crc      = modbus_crc_step(rx_crc, b);
        end else if (b == SyncFirst) begin
          restart_frame();
        end else begin
          drop_frame();
        end
      end
      CollectBody: begin
        if (rx_fill >= FrameLen) begin
          drop_frame();
        end else begin
          rx_store[rx_fill] = b;
          if (rx_fill < FrameLen - 2) rx_crc = modbus_crc_step(rx_crc, b);
          rx_fill = rx_fill + 7'd1;
          if (rx_fill == FrameLen) begin
            if ({rx_store[FrameLen-1], rx_store[FrameLen-2]} == rx_crc) begin
              for (int k = 0; k < FrameLen; k++) begin
                w.data = rx_store[k];
                w.pos  = 6'(k);
                w.last = (k == FrameLen - 1);
                frame_words_q.push_back(w);
              end
              drop_frame();
            end else if (b == SyncFirst) begin
              restart_frame();
            end else begin
              drop_frame();
            end
          end
        end
      end
      default: drop_frame();
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic frame_t seal_frame(frame_t f);
    logic [15:0] crc;
    crc = CrcSeed;
    for (int i = 0; i < FrameLen - 2; i++) crc = modbus_crc_step(crc, f[i]);
    f[FrameLen-2] = crc[7:0];
    f[FrameLen-1] = crc[15:8];
    return f;
  endfunction

  function automatic frame_t good_frame();
    frame_t f;
    int     r;
    f[0] = SyncFirst;
    f[1] = SyncSecond;
    for (int i = 2; i < FrameLen - 2; i++) begin
      r    = $urandom_range(0, 15);
      f[i] = (r == 0) ? SyncFirst : (r == 1) ? SyncSecond : 8'($urandom);
    end
    return seal_frame(f);
  endfunction

  task automatic queue_frame(frame_t f, int from, int upto);
    for (int i = from; i < upto; i++) link_bytes_q.push_back(f[i]);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) track_link_byte(in_byte);
      if (!in_valid || !in_stall_o) begin
        if (tx_gap > 0) begin
          tx_gap   = tx_gap - 1;
          in_valid <= 1'b0;
        end else if (link_bytes_q.size() > 0) begin
          in_valid <= 1'b1;
          in_byte  <= link_bytes_q.pop_front();
          tx_gap   = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk_i) begin
    frame_word_t w;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (frame_words_q.size() == 0) begin
          $display("%0t unexpected word: expected none, actual byte %h pos %0d last %b",
                   $time, frame_byte_o, byte_position_o, last_byte_o);
          errors++;
        end else begin
          w = frame_words_q.pop_front();
          if (frame_byte_o !== w.data) begin
            $display("%0t frame_byte: expected %h actual %h", $time, w.data, frame_byte_o);
            errors++;
          end
          if (byte_position_o !== w.pos) begin
            $display("%0t byte_position: expected %0d actual %0d",
                     $time, w.pos, byte_position_o);
            errors++;
          end
          if (last_byte_o !== w.last) begin
            $display("%0t last_byte: expected %b actual %b", $time, w.last, last_byte_o);
            errors++;
          end
        end
        words_seen++;
        // long hold-off so the block backs up into its input
        if (words_seen == 32 || words_seen == 128) hold_left = HoldOff;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap = rx_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        rx_gap = pick_gap();
      end
    end
  end

  // stretches with no idling on either side
  always @(posedge clk_i) begin
    if (calm_timer == 0) begin
      calm       <= ($urandom_range(0, 3) == 0);
      calm_timer <= $urandom_range(30, 120);
    end else begin
      calm_timer <= calm_timer - 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t watchdog: no word moved for %0d cycles", $time, idle_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    frame_t f;
    frame_t g;
    int     r;
    logic [7:0] b;

    // noise while hunting, broken header, repeated header start
    link_bytes_q.push_back(8'h00);
    link_bytes_q.push_back(8'hFF);
    link_bytes_q.push_back(SyncSecond);
    link_bytes_q.push_back(SyncFirst);
    link_bytes_q.push_back(8'h51);
    link_bytes_q.push_back(SyncFirst);
    f = good_frame();
    for (int i = 2; i < FrameLen - 2; i++) f[i] = i[0] ? 8'hFF : 8'h00;
    queue_frame(seal_frame(f), 0, FrameLen);

    while (link_bytes_q.size() < 420) begin
      r = $urandom_range(0, 99);
      f = good_frame();
      if (r < 50) begin
        queue_frame(f, 0, FrameLen);
      end else if (r < 62) begin
        f[$urandom_range(0, FrameLen - 1)] ^= 8'(1 << $urandom_range(0, 7));
        queue_frame(f, 0, FrameLen);
      end else if (r < 74) begin
        // bad CRC ending in 'S', then the rest of a good frame after it
        if (f[FrameLen-1] == SyncFirst) f[FrameLen-2] ^= 8'h01;
        f[FrameLen-1] = SyncFirst;
        queue_frame(f, 0, FrameLen);
        g = good_frame();
        queue_frame(g, 1, FrameLen);
      end else if (r < 84) begin
        repeat ($urandom_range(1, 3)) link_bytes_q.push_back(SyncFirst);
        if ($urandom_range(0, 1) == 0) begin
          b = 8'($urandom);
          if (b == SyncSecond) b = 8'h00;
          link_bytes_q.push_back(b);
        end else begin
          queue_frame(f, 1, FrameLen);
        end
      end else if (r < 92) begin
        queue_frame(f, 0, $urandom_range(2, FrameLen - 1));
      end else begin
        repeat ($urandom_range(1, 6)) link_bytes_q.push_back(8'($urandom));
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (link_bytes_q.size() != 0 || in_valid || frame_words_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TailWait) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
